// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page replacement block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lru_pkg.sv -----
// ---------------------------------------------------------------------------
// LRU page replacement package
// Field widths, controller state encoding and command/status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru_pkg;

    localparam int unsigned PAGE_W       = 20;
    localparam int unsigned CFG_W        = 5;
    localparam int unsigned RESET_FRAMES = 16;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } t_lru_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the page number of an accepted reference
        logic cfg_write;  // load the frame count and empty the store
        logic update;     // resolve the latched reference and post its result
    } t_lru_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // the result register can take a new result this cycle
    } t_lru_status;

endpackage

// ----- rtl/lru_if.sv -----
// ---------------------------------------------------------------------------
// LRU page replacement channel interfaces
// Reference, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lru_req_if;
    logic                         valid;
    logic                         ready;
    logic [lru_pkg::PAGE_W-1:0]   page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

interface lru_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lru_pkg::CFG_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lru_ctrl.sv -----
// ---------------------------------------------------------------------------
// LRU controller
// Sequences one reference at a time: accept, then resolve and post result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lru_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  lru_pkg::t_lru_status  i_status,
    output lru_pkg::t_lru_cmd     o_cmd
);
    import lru_pkg::*;

    t_lru_state r_state;
    t_lru_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_req_ready   = 1'b0;
        o_cfg_ready   = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready     = 1'b1;
                o_cfg_ready     = 1'b1;
                o_cmd.cfg_write = i_cfg_valid;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // Wait here while the previous result has not been taken.
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_SAME(a_update_needs_room, i_clk, i_rst_n, o_cmd.update, i_status.out_free, "update without room for the result")
    `ASSERT_NEXT(a_capture_to_lookup, i_clk, i_rst_n, o_cmd.capture, r_state == ST_LOOKUP, "accepted reference not followed by lookup")

endmodule

// ----- rtl/lru_dp.sv -----
// ---------------------------------------------------------------------------
// LRU datapath
// Frame tags with valid bits and recency ranks, fill count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lru_dp #(
    parameter int unsigned MAX_FRAMES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lru_pkg::t_lru_cmd           i_cmd,
    output lru_pkg::t_lru_status        o_status,
    input  logic [lru_pkg::PAGE_W-1:0]  i_page_number,
    input  logic [lru_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_out_hit
);
    import lru_pkg::*;

    localparam int unsigned RW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
    localparam int unsigned RST_FRAMES =
        (RESET_FRAMES > MAX_FRAMES) ? MAX_FRAMES : RESET_FRAMES;

    logic [PAGE_W-1:0]     r_page [MAX_FRAMES];
    logic [RW-1:0]         r_rank [MAX_FRAMES];
    logic [RW-1:0]         n_rank [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [MAX_FRAMES-1:0] n_valid;
    logic [CW-1:0]         r_filled;
    logic [CW-1:0]         n_filled;
    logic [CW-1:0]         r_frame_limit;
    logic [CW-1:0]         n_frame_limit;
    logic [PAGE_W-1:0]     r_req_page;
    logic                  r_out_valid;
    logic                  r_out_hit;

    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] victim;
    logic [MAX_FRAMES-1:0] kept;
    logic [MAX_FRAMES-1:0] slot;
    logic                  hit;
    logic                  full;
    logic [RW-1:0]         hit_rank;
    logic                  slot_found;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_hit         = r_out_hit;

    // Tag compare, victim and free-slot selection for the latched page.
    always_comb begin
        hit_rank   = '0;
        slot       = '0;
        slot_found = 1'b0;
        full       = (r_filled == r_frame_limit);
        for (int i = 0; i < MAX_FRAMES; i++) begin
            match[i] = r_valid[i] && (r_page[i] == r_req_page);
        end
        hit = |match;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
            // The least recently used frame holds the highest rank.
            victim[i] = r_valid[i] && full && !hit &&
                        (CW'(r_rank[i]) == r_filled - CW'(1));
        end
        kept = r_valid & ~victim;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (!kept[i] && !slot_found) begin
                slot[i]    = 1'b1;
                slot_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid       = r_valid;
        n_filled      = r_filled;
        n_frame_limit = r_frame_limit;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (i_cmd.cfg_write) begin
            n_valid  = '0;
            n_filled = '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                n_rank[i] = '0;
            end
            if (i_cfg_data == '0) begin
                n_frame_limit = CW'(1);
            end else if (32'(i_cfg_data) > 32'(MAX_FRAMES)) begin
                n_frame_limit = CW'(MAX_FRAMES);
            end else begin
                n_frame_limit = CW'(i_cfg_data);
            end
        end else if (i_cmd.update) begin
            if (hit) begin
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    if (match[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        n_rank[i] = r_rank[i] + RW'(1);
                    end
                end
            end else begin
                n_valid = kept | slot;
                if (!full) begin
                    n_filled = r_filled + CW'(1);
                end
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    if (kept[i]) begin
                        n_rank[i] = r_rank[i] + RW'(1);
                    end else begin
                        n_rank[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_filled      <= '0;
            r_frame_limit <= CW'(RST_FRAMES);
            r_out_valid   <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid       <= n_valid;
            r_filled      <= n_filled;
            r_frame_limit <= n_frame_limit;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_page <= i_page_number;
        end
        if (i_cmd.update) begin
            r_out_hit <= hit;
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i_cmd.update && !hit && slot[i]) begin
                r_page[i] <= r_req_page;
            end
        end
    end

    `ASSERT_SAME(a_single_match, i_clk, i_rst_n, i_cmd.update, $onehot0(match), "page resident in more than one frame")
    `ASSERT_SAME(a_fill_count, i_clk, i_rst_n, 1'b1, $countones(r_valid) == r_filled, "fill count differs from valid frames")
    `ASSERT_SAME(a_victim_found, i_clk, i_rst_n, i_cmd.update && !hit && full, $onehot(victim), "no unique victim on a full fault")
    `ASSERT_SAME(a_within_limit, i_clk, i_rst_n, 1'b1, r_filled <= r_frame_limit, "more frames filled than configured")

endmodule

// ----- rtl/lru_page_replacement_core.sv -----
// ---------------------------------------------------------------------------
// LRU page replacement core
// Fully associative least-recently-used frame store with hit/fault result.
// ---------------------------------------------------------------------------
// Each reference passes through the controller's idle and lookup states: idle
// accepts the page number, then lookup compares it against all frame tags,
// updates the recency ranks and posts the hit flag to the result register;
// the lookup waits while the previous result is still held, and no new
// reference is accepted until it is done. A frame count write is a single transfer on the
// configuration channel that empties the store at once; values of zero read
// as one and values above MAX_FRAMES read as MAX_FRAMES. After reset all
// frames are empty and the frame count is 16 (or MAX_FRAMES if smaller).
`timescale 1ns / 1ps

module lru_page_replacement_core #(
    parameter int unsigned MAX_FRAMES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lru_req_if.sink   i_req,
    lru_rsp_if.source o_rsp,
    lru_cfg_if.sink   i_cfg
);
    import lru_pkg::*;

    t_lru_cmd    cmd;
    t_lru_status status;

    lru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lru_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_page_number (i_req.page_number),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_out_hit     (o_rsp.hit)
    );

endmodule
